// ===== rtl/fft8_pkg.sv =====
// Package with the constants, types and fixed-point helpers of the 8-point FFT unit.
`default_nettype none

package fft8_pkg;

  localparam int unsigned FRACTION_BITS = 8;
  localparam int unsigned SAMPLE_W      = 8;
  localparam int unsigned BIN_W         = 3;
  localparam int unsigned NUM_BINS      = 8;
  localparam int unsigned PART_W        = 20;
  localparam int unsigned SUM_W         = 12;
  localparam int unsigned CONST_W       = 18;
  localparam int unsigned PROD_W        = SUM_W + CONST_W;
  localparam int unsigned ACC_W         = 40;
  localparam int unsigned ROUND_SH      = 16 - FRACTION_BITS;
  localparam int unsigned ROUND_HALF    = (ROUND_SH == 0) ? 0 : (1 << (ROUND_SH - 1));

  localparam logic signed [CONST_W-1:0] HALF_ROOT2_Q16 = 18'sd46341;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic        [PART_W-1:0]   part_t;
  typedef logic        [BIN_W-1:0]    bin_t;

  // Rounds a Q.16 product to FRACTION_BITS fraction bits, halves towards plus infinity.
  function automatic prod_t round_prod(prod_t prod);
    prod_t biased;
    biased = prod + PROD_W'(ROUND_HALF);
    return biased >>> ROUND_SH;
  endfunction

  // Scales an integer term to FRACTION_BITS fraction bits, adds a rounded product and wraps.
  function automatic part_t fixed_part(sum_t d, prod_t r);
    logic signed [ACC_W-1:0] acc;
    acc = (ACC_W'(d) <<< FRACTION_BITS) + ACC_W'(r);
    return acc[PART_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fft_8_point_real_input_unit.sv =====
// Top level of the 8-point real-input FFT unit: butterfly, multiply and output stages.
// The first bin of a request appears after the butterfly, multiply and bank registers.
// Bins leave one per cycle unless stalled; new requests can enter while the bank drains.
// The output rate of one bin per cycle over the eight-entry result bank sets the throughput.
// Reset is asynchronous and active low; it clears the valid bits and the bin counter.
`default_nettype none

module fft_8_point_real_input_unit (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire fft8_pkg::sample_t   sample_0_i,
  input  wire fft8_pkg::sample_t   sample_1_i,
  input  wire fft8_pkg::sample_t   sample_2_i,
  input  wire fft8_pkg::sample_t   sample_3_i,
  input  wire fft8_pkg::sample_t   sample_4_i,
  input  wire fft8_pkg::sample_t   sample_5_i,
  input  wire fft8_pkg::sample_t   sample_6_i,
  input  wire fft8_pkg::sample_t   sample_7_i,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output fft8_pkg::bin_t           bin_index_o,
  output logic signed [fft8_pkg::PART_W-1:0] real_part_o,
  output logic signed [fft8_pkg::PART_W-1:0] imag_part_o,
  output logic                     last_bin_o
);

  // Butterfly stage.
  logic                s1_vld_q;
  fft8_pkg::sum_t      s1_d0_q, s1_d4_q, s1_d1_q, s1_d2_q;
  fft8_pkg::sum_t      s1_e1_q, s1_e2_q, s1_p1_q, s1_q1_q;
  fft8_pkg::sum_t      s1_d0_d, s1_d4_d, s1_d1_d, s1_d2_d;
  fft8_pkg::sum_t      s1_e1_d, s1_e2_d, s1_p1_d, s1_q1_d;
  fft8_pkg::sum_t      x0, x1, x2, x3, x4, x5, x6, x7;

  // Multiply stage.
  logic                s2_vld_q;
  fft8_pkg::sum_t      s2_d0_q, s2_d4_q, s2_d1_q, s2_d2_q, s2_e1_q, s2_e2_q;
  fft8_pkg::prod_t     s2_pp_q, s2_pq_q;
  fft8_pkg::prod_t     s2_pp_d, s2_pq_d;

  // Result bank and output sequencer.
  logic                bank_vld_q;
  fft8_pkg::bin_t      cnt_q, cnt_d;
  fft8_pkg::part_t     bank_re_q [fft8_pkg::NUM_BINS];
  fft8_pkg::part_t     bank_im_q [fft8_pkg::NUM_BINS];
  fft8_pkg::part_t     bank_re_d [fft8_pkg::NUM_BINS];
  fft8_pkg::part_t     bank_im_d [fft8_pkg::NUM_BINS];
  fft8_pkg::prod_t     r_p, r_np, r_q, r_nq;

  logic                out_take, last_take, bank_free, bank_load, s2_ready, s1_ready, in_take;

  assign out_take  = bank_vld_q && !out_stall_i;
  assign last_take = out_take && (cnt_q == fft8_pkg::bin_t'(fft8_pkg::NUM_BINS - 1));
  assign bank_free = !bank_vld_q || last_take;
  assign bank_load = s2_vld_q && bank_free;
  assign s2_ready  = !s2_vld_q || bank_load;
  assign s1_ready  = !s1_vld_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign in_take   = in_valid_i && s1_ready;

  assign x0 = fft8_pkg::SUM_W'(sample_0_i);
  assign x1 = fft8_pkg::SUM_W'(sample_1_i);
  assign x2 = fft8_pkg::SUM_W'(sample_2_i);
  assign x3 = fft8_pkg::SUM_W'(sample_3_i);
  assign x4 = fft8_pkg::SUM_W'(sample_4_i);
  assign x5 = fft8_pkg::SUM_W'(sample_5_i);
  assign x6 = fft8_pkg::SUM_W'(sample_6_i);
  assign x7 = fft8_pkg::SUM_W'(sample_7_i);

  always_comb begin
    s1_d0_d = ((x0 + x4) + (x2 + x6)) + ((x1 + x5) + (x3 + x7));
    s1_d4_d = ((x0 + x4) + (x2 + x6)) - ((x1 + x5) + (x3 + x7));
    s1_d1_d = x0 - x4;
    s1_d2_d = (x0 + x4) - (x2 + x6);
    s1_e1_d = x6 - x2;
    s1_e2_d = (x3 + x7) - (x1 + x5);
    s1_p1_d = (x1 - x3) + (x7 - x5);
    s1_q1_d = (x5 - x1) + (x7 - x3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_ready) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_d0_q <= s1_d0_d;
      s1_d4_q <= s1_d4_d;
      s1_d1_q <= s1_d1_d;
      s1_d2_q <= s1_d2_d;
      s1_e1_q <= s1_e1_d;
      s1_e2_q <= s1_e2_d;
      s1_p1_q <= s1_p1_d;
      s1_q1_q <= s1_q1_d;
    end
  end

  assign s2_pp_d = fft8_pkg::PROD_W'(s1_p1_q) * fft8_pkg::PROD_W'(fft8_pkg::HALF_ROOT2_Q16);
  assign s2_pq_d = fft8_pkg::PROD_W'(s1_q1_q) * fft8_pkg::PROD_W'(fft8_pkg::HALF_ROOT2_Q16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_ready) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_vld_q) begin
      s2_d0_q <= s1_d0_q;
      s2_d4_q <= s1_d4_q;
      s2_d1_q <= s1_d1_q;
      s2_d2_q <= s1_d2_q;
      s2_e1_q <= s1_e1_q;
      s2_e2_q <= s1_e2_q;
      s2_pp_q <= s2_pp_d;
      s2_pq_q <= s2_pq_d;
    end
  end

  always_comb begin
    r_p  = fft8_pkg::round_prod(s2_pp_q);
    r_np = fft8_pkg::round_prod(-s2_pp_q);
    r_q  = fft8_pkg::round_prod(s2_pq_q);
    r_nq = fft8_pkg::round_prod(-s2_pq_q);

    bank_re_d[0] = fft8_pkg::fixed_part(s2_d0_q, '0);
    bank_im_d[0] = '0;
    bank_re_d[1] = fft8_pkg::fixed_part(s2_d1_q, r_p);
    bank_im_d[1] = fft8_pkg::fixed_part(s2_e1_q, r_q);
    bank_re_d[2] = fft8_pkg::fixed_part(s2_d2_q, '0);
    bank_im_d[2] = fft8_pkg::fixed_part(s2_e2_q, '0);
    bank_re_d[3] = fft8_pkg::fixed_part(s2_d1_q, r_np);
    bank_im_d[3] = fft8_pkg::fixed_part(-s2_e1_q, r_q);
    bank_re_d[4] = fft8_pkg::fixed_part(s2_d4_q, '0);
    bank_im_d[4] = '0;
    bank_re_d[5] = fft8_pkg::fixed_part(s2_d1_q, r_np);
    bank_im_d[5] = fft8_pkg::fixed_part(s2_e1_q, r_nq);
    bank_re_d[6] = fft8_pkg::fixed_part(s2_d2_q, '0);
    bank_im_d[6] = fft8_pkg::fixed_part(-s2_e2_q, '0);
    bank_re_d[7] = fft8_pkg::fixed_part(s2_d1_q, r_p);
    bank_im_d[7] = fft8_pkg::fixed_part(-s2_e1_q, r_nq);
  end

  always_comb begin
    cnt_d = cnt_q;
    if (out_take) begin
      cnt_d = cnt_q + fft8_pkg::bin_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_vld_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (bank_free) begin
        bank_vld_q <= s2_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (bank_load) begin
      bank_re_q <= bank_re_d;
      bank_im_q <= bank_im_d;
    end
  end

  assign out_valid_o = bank_vld_q;
  assign bin_index_o = cnt_q;
  assign real_part_o = bank_re_q[cnt_q];
  assign imag_part_o = bank_im_q[cnt_q];
  assign last_bin_o  = (cnt_q == fft8_pkg::bin_t'(fft8_pkg::NUM_BINS - 1));

endmodule

`default_nettype wire
